/* design/olb_pkg.sv */
`timescale 1ns / 1ps
// Shared widths, types and constants of the layer opacity over blend block.
package olb_pkg;

  localparam int PIX_W      = 8;   // one color or alpha channel
  localparam int S_W        = 16;  // scaled source alpha, units of 1/65025
  localparam int W_W        = 24;  // alpha weights and result alpha
  localparam int P_W        = 32;  // weighted color products
  localparam int NUM_W      = 34;  // dividend and shifted divisor
  localparam int DEN_W      = 25;  // divisor
  localparam int Q_W        = 9;   // quotient, one bit above the pixel range
  localparam int NUM_COLORS = 3;
  localparam int NUM_LANES  = NUM_COLORS + 1;
  localparam int LANE_ALPHA = NUM_COLORS;
  localparam int DIV_STEPS  = Q_W;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [S_W-1:0]   s_t;
  typedef logic [W_W-1:0]   w_t;
  typedef logic [P_W-1:0]   p_t;
  typedef logic [NUM_W-1:0] num_t;
  typedef logic [DEN_W-1:0] den_t;
  typedef logic [Q_W-1:0]   q_t;

  localparam s_t   FULL_SCALE    = 16'd65025;
  localparam pix_t PIX_MAX       = 8'd255;
  localparam pix_t OPACITY_RESET = 8'd255;
  // alpha lane: round(A / 65025) = floor((2A + 65025) / 130050)
  localparam den_t ALPHA_DEN     = 25'd130050;
  localparam num_t ALPHA_BIAS    = 34'd65025;

  typedef struct packed {
    pix_t red;
    pix_t green;
    pix_t blue;
    pix_t alpha;
  } rgba_t;

  typedef struct packed {
    logic  zero;  // result alpha is zero: pass destination
    rgba_t dst;
  } side_t;

  typedef struct packed {
    num_t [NUM_LANES-1:0] num;
    den_t                 den;
    side_t                side;
  } div_req_t;

  typedef struct packed {
    q_t [NUM_LANES-1:0] quo;
    side_t              side;
  } div_rsp_t;

  function automatic pix_t sat_pix(q_t q);
    return (q > q_t'(PIX_MAX)) ? PIX_MAX : pix_t'(q);
  endfunction

endpackage

/* design/olb_if.sv */
`timescale 1ns / 1ps
// Channel interfaces: pixel input, blended pixel output and opacity write.
interface olb_in_if;
  logic                valid;
  logic                ready;
  logic [olb_pkg::PIX_W-1:0] src_red;
  logic [olb_pkg::PIX_W-1:0] src_green;
  logic [olb_pkg::PIX_W-1:0] src_blue;
  logic [olb_pkg::PIX_W-1:0] src_alpha;
  logic [olb_pkg::PIX_W-1:0] dst_red;
  logic [olb_pkg::PIX_W-1:0] dst_green;
  logic [olb_pkg::PIX_W-1:0] dst_blue;
  logic [olb_pkg::PIX_W-1:0] dst_alpha;

  modport source (
    output valid, src_red, src_green, src_blue, src_alpha,
    output dst_red, dst_green, dst_blue, dst_alpha,
    input  ready
  );
  modport sink (
    input  valid, src_red, src_green, src_blue, src_alpha,
    input  dst_red, dst_green, dst_blue, dst_alpha,
    output ready
  );
endinterface

interface olb_out_if;
  logic                valid;
  logic                ready;
  logic [olb_pkg::PIX_W-1:0] out_red;
  logic [olb_pkg::PIX_W-1:0] out_green;
  logic [olb_pkg::PIX_W-1:0] out_blue;
  logic [olb_pkg::PIX_W-1:0] out_alpha;

  modport source (output valid, out_red, out_green, out_blue, out_alpha, input ready);
  modport sink (input valid, out_red, out_green, out_blue, out_alpha, output ready);
endinterface

interface olb_cfg_if;
  logic                valid;
  logic                ready;
  logic [olb_pkg::PIX_W-1:0] layer_opacity;

  modport source (output valid, layer_opacity, input ready);
  modport sink (input valid, layer_opacity, output ready);
endinterface

/* design/olb_div.sv */
`timescale 1ns / 1ps
// Pipelined restoring divider: four lanes, one quotient bit per stage.
module olb_div (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              req_valid,
  output logic              req_ready,
  input  olb_pkg::div_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output olb_pkg::div_rsp_t rsp
);

  localparam int STEPS = olb_pkg::DIV_STEPS;
  localparam int NST   = STEPS + 1;
  localparam int L     = olb_pkg::NUM_LANES;

  logic [NST-1:0] v_r;
  logic [NST:0]   ld;

  olb_pkg::div_req_t req_r;

  olb_pkg::num_t [L-1:0] rem_r  [0:STEPS-2];
  olb_pkg::den_t         den_r  [0:STEPS-2];
  olb_pkg::q_t   [L-1:0] quo_r  [0:STEPS-1];
  olb_pkg::side_t        side_r [0:STEPS-1];

  // a stage loads when it is empty or its content moves on
  always_comb begin
    ld[NST] = rsp_ready;
    for (int s = NST - 1; s >= 0; s--) begin
      ld[s] = !v_r[s] || ld[s+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (ld[0]) begin
        v_r[0] <= req_valid;
      end
      for (int s = 1; s < NST; s++) begin
        if (ld[s]) begin
          v_r[s] <= v_r[s-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      req_r <= req;
    end
  end

  genvar k, j;
  for (k = 0; k < STEPS; k++) begin : g_step
    localparam int SH = STEPS - 1 - k;

    olb_pkg::num_t [L-1:0] rem_in;
    olb_pkg::q_t   [L-1:0] quo_in;
    olb_pkg::den_t         den_in;
    olb_pkg::side_t        side_in;
    olb_pkg::num_t         cand_c;
    olb_pkg::num_t         cand_a;
    olb_pkg::num_t [L-1:0] cand;
    logic          [L-1:0] ge;
    olb_pkg::q_t   [L-1:0] quo_nxt;

    if (k == 0) begin : g_first
      assign rem_in  = req_r.num;
      assign quo_in  = '0;
      assign den_in  = req_r.den;
      assign side_in = req_r.side;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign quo_in  = quo_r[k-1];
      assign den_in  = den_r[k-1];
      assign side_in = side_r[k-1];
    end

    assign cand_c = olb_pkg::num_t'(den_in) << SH;
    assign cand_a = olb_pkg::num_t'(olb_pkg::ALPHA_DEN) << SH;

    for (j = 0; j < L; j++) begin : g_lane
      assign cand[j]    = (j == olb_pkg::LANE_ALPHA) ? cand_a : cand_c;
      assign ge[j]      = rem_in[j] >= cand[j];
      assign quo_nxt[j] = quo_in[j] | (olb_pkg::q_t'(ge[j]) << SH);
    end

    always_ff @(posedge clk) begin
      if (ld[k+1]) begin
        quo_r[k]  <= quo_nxt;
        side_r[k] <= side_in;
      end
    end

    if (k < STEPS - 1) begin : g_rem
      olb_pkg::num_t [L-1:0] rem_nxt;
      for (j = 0; j < L; j++) begin : g_sub
        assign rem_nxt[j] = ge[j] ? (rem_in[j] - cand[j]) : rem_in[j];
      end
      always_ff @(posedge clk) begin
        if (ld[k+1]) begin
          rem_r[k] <= rem_nxt;
          den_r[k] <= den_in;
        end
      end
    end
  end

  assign req_ready = ld[0];
  assign rsp_valid = v_r[NST-1];
  assign rsp.quo   = quo_r[STEPS-1];
  assign rsp.side  = side_r[STEPS-1];

endmodule

/* design/layer_opacity_over_blend_top.sv */
`timescale 1ns / 1ps
// Top level: source-over blend of one straight-alpha RGBA pixel pair per cycle when not stalled.
//
// Channels: in_px carries a source and a destination pixel, out_px the blended
// pixel, cfg_wr the layer opacity (255 = fully opaque). All use valid/ready; a
// transaction completes at a clock edge with both high. cfg_wr is always ready;
// write it only while no pixel is in flight.
// Throughput: one pixel per clock, sustained while out_px.ready is high, no dependence between pixels.
// From input transaction to out_px.valid a pixel passes three multiply stages
// (opacity scale, alpha weights, color products), the divider request register,
// nine divider stages (one quotient bit each) and the output register.
// The nine-stage restoring divider sets the depth.
// A zero result alpha passes the destination pixel through unchanged.
// Reset (rst_n low, synchronous) empties the pipeline and sets opacity to 255.
// When out_px.ready is low the output holds; earlier stages keep filling
// bubbles, so in_px.ready drops only once every stage holds a pixel.
module layer_opacity_over_blend_top (
  input  logic       clk,
  input  logic       rst_n,
  olb_in_if.sink     in_px,
  olb_out_if.source  out_px,
  olb_cfg_if.sink    cfg_wr
);

  localparam int NC = olb_pkg::NUM_COLORS;
  localparam int FS = 3;

  olb_pkg::pix_t opacity_r;

  logic [FS-1:0] fv_r;
  logic [FS:0]   fld;

  // stage 1: scaled source alpha
  olb_pkg::s_t              s_r;
  olb_pkg::pix_t [NC-1:0]   f1_src_r;
  olb_pkg::rgba_t           f1_dst_r;
  // stage 2: source and destination weights
  olb_pkg::w_t              ws_r;
  olb_pkg::w_t              wd_r;
  olb_pkg::pix_t [NC-1:0]   f2_src_r;
  olb_pkg::rgba_t           f2_dst_r;
  // stage 3: weighted color products and result alpha
  olb_pkg::p_t   [NC-1:0]   ps_r;
  olb_pkg::p_t   [NC-1:0]   pd_r;
  olb_pkg::w_t              a_r;
  olb_pkg::rgba_t           f3_dst_r;

  olb_pkg::pix_t [NC-1:0]   in_src;
  olb_pkg::rgba_t           in_dst;
  olb_pkg::pix_t [NC-1:0]   f2_dstc;
  olb_pkg::p_t   [NC-1:0]   ps_nxt;
  olb_pkg::p_t   [NC-1:0]   pd_nxt;
  olb_pkg::num_t [NC-1:0]   csum;

  olb_pkg::div_req_t div_req;
  olb_pkg::div_rsp_t div_rsp;
  logic              div_req_ready;
  logic              div_rsp_valid;

  logic              ov_r;
  logic              out_ld;
  olb_pkg::rgba_t    out_r;
  olb_pkg::rgba_t    out_nxt;

  // opacity register
  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      opacity_r <= olb_pkg::OPACITY_RESET;
    end else if (cfg_wr.valid) begin
      opacity_r <= cfg_wr.layer_opacity;
    end
  end

  // front pipeline control
  always_comb begin
    fld[FS] = div_req_ready;
    for (int s = FS - 1; s >= 0; s--) begin
      fld[s] = !fv_r[s] || fld[s+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= '0;
    end else begin
      if (fld[0]) begin
        fv_r[0] <= in_px.valid;
      end
      for (int s = 1; s < FS; s++) begin
        if (fld[s]) begin
          fv_r[s] <= fv_r[s-1];
        end
      end
    end
  end

  assign in_px.ready = fld[0];

  assign in_src[0]    = in_px.src_red;
  assign in_src[1]    = in_px.src_green;
  assign in_src[2]    = in_px.src_blue;
  assign in_dst.red   = in_px.dst_red;
  assign in_dst.green = in_px.dst_green;
  assign in_dst.blue  = in_px.dst_blue;
  assign in_dst.alpha = in_px.dst_alpha;

  always_ff @(posedge clk) begin
    if (fld[0]) begin
      s_r      <= olb_pkg::s_t'(in_px.src_alpha) * olb_pkg::s_t'(opacity_r);
      f1_src_r <= in_src;
      f1_dst_r <= in_dst;
    end
  end

  always_ff @(posedge clk) begin
    if (fld[1]) begin
      ws_r     <= olb_pkg::w_t'(s_r) * olb_pkg::w_t'(olb_pkg::PIX_MAX);
      wd_r     <= olb_pkg::w_t'(f1_dst_r.alpha) * olb_pkg::w_t'(olb_pkg::FULL_SCALE - s_r);
      f2_src_r <= f1_src_r;
      f2_dst_r <= f1_dst_r;
    end
  end

  assign f2_dstc[0] = f2_dst_r.red;
  assign f2_dstc[1] = f2_dst_r.green;
  assign f2_dstc[2] = f2_dst_r.blue;

  always_comb begin
    for (int c = 0; c < NC; c++) begin
      ps_nxt[c] = olb_pkg::p_t'(ws_r) * olb_pkg::p_t'(f2_src_r[c]);
      pd_nxt[c] = olb_pkg::p_t'(wd_r) * olb_pkg::p_t'(f2_dstc[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (fld[2]) begin
      ps_r     <= ps_nxt;
      pd_r     <= pd_nxt;
      a_r      <= ws_r + wd_r;
      f3_dst_r <= f2_dst_r;
    end
  end

  // color dividend 2C + A, divisor 2A, rounds to nearest with ties up
  always_comb begin
    for (int c = 0; c < NC; c++) begin
      csum[c]        = olb_pkg::num_t'(ps_r[c]) + olb_pkg::num_t'(pd_r[c]);
      div_req.num[c] = {csum[c][olb_pkg::NUM_W-2:0], 1'b0} + olb_pkg::num_t'(a_r);
    end
    div_req.num[olb_pkg::LANE_ALPHA] = olb_pkg::num_t'({a_r, 1'b0}) + olb_pkg::ALPHA_BIAS;
    div_req.den       = {a_r, 1'b0};
    div_req.side.zero = (a_r == '0);
    div_req.side.dst  = f3_dst_r;
  end

  olb_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (fv_r[FS-1]),
    .req_ready (div_req_ready),
    .req       (div_req),
    .rsp_valid (div_rsp_valid),
    .rsp_ready (out_ld),
    .rsp       (div_rsp)
  );

  // output register
  assign out_ld = !ov_r || out_px.ready;

  always_comb begin
    if (div_rsp.side.zero) begin
      out_nxt = div_rsp.side.dst;
    end else begin
      out_nxt.red   = olb_pkg::sat_pix(div_rsp.quo[0]);
      out_nxt.green = olb_pkg::sat_pix(div_rsp.quo[1]);
      out_nxt.blue  = olb_pkg::sat_pix(div_rsp.quo[2]);
      out_nxt.alpha = olb_pkg::sat_pix(div_rsp.quo[olb_pkg::LANE_ALPHA]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (out_ld) begin
      ov_r <= div_rsp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld) begin
      out_r <= out_nxt;
    end
  end

  assign out_px.valid     = ov_r;
  assign out_px.out_red   = out_r.red;
  assign out_px.out_green = out_r.green;
  assign out_px.out_blue  = out_r.blue;
  assign out_px.out_alpha = out_r.alpha;

endmodule

/* design/olb_checker.sv */
`timescale 1ns / 1ps
// Port-level checks of the blend block, bound to its top level.
module olb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_data
);

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out valid after reset");

  // a ready sink always frees a slot at the input
  a_no_input_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output is drained");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output transaction dropped under stall");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("output pixel changed under stall");

endmodule

bind layer_opacity_over_blend_top olb_checker u_olb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_px.ready),
  .out_valid (out_px.valid),
  .out_ready (out_px.ready),
  .out_data  ({out_px.out_red, out_px.out_green, out_px.out_blue, out_px.out_alpha})
);

/* sim/tb_layer_opacity_over_blend_top.sv */
`timescale 1ns / 1ps
// Testbench: layer opacity over blend, self-checked against an exact integer blend predictor.
module tb_layer_opacity_over_blend_top;

  localparam longint unsigned OPAQUE_UNIT = 65025;  // 1.0 in units of 1/(255*255)
  localparam int STUCK_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_PER_PHASE = 100;

  logic clk;
  logic rst_n;

  olb_in_if  in_px ();
  olb_out_if out_px ();
  olb_cfg_if cfg_wr ();

  layer_opacity_over_blend_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_px  (in_px),
    .out_px (out_px),
    .cfg_wr (cfg_wr)
  );

  olb_pkg::rgba_t expected_px_q[$];
  olb_pkg::pix_t  opacity_model;
  int             mismatch_cnt = 0;
  int             stuck_cycles = 0;
  bit             src_gaps = 1'b0;
  bit             sink_pacing = 1'b0;
  olb_pkg::rgba_t got_px;
  olb_pkg::rgba_t want_px;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // ---------------------------------------------------------------------------
  // Blend predictor: exact integer source-over with rounding to nearest, ties up
  // ---------------------------------------------------------------------------
  function automatic olb_pkg::pix_t div_round_sat(longint unsigned num,
                                                  longint unsigned den);
    longint unsigned q;
    q = (2 * num + den) / (2 * den);
    return (q > 255) ? 8'd255 : olb_pkg::pix_t'(q);
  endfunction

  function automatic olb_pkg::rgba_t blend_over(olb_pkg::rgba_t src, olb_pkg::rgba_t dst,
                                                olb_pkg::pix_t opacity);
    longint unsigned src_weight;
    longint unsigned dst_weight;
    longint unsigned sum_alpha;
    olb_pkg::rgba_t res;
    src_weight = src.alpha;
    src_weight = src_weight * opacity;
    dst_weight = dst.alpha;
    dst_weight = dst_weight * (OPAQUE_UNIT - src_weight);
    sum_alpha = 255 * src_weight + dst_weight;
    // nothing visible on either side: destination passes through
    if (sum_alpha == 0) return dst;
    res.red   = div_round_sat(255 * src_weight * src.red + dst_weight * dst.red, sum_alpha);
    res.green = div_round_sat(255 * src_weight * src.green + dst_weight * dst.green,
                              sum_alpha);
    res.blue  = div_round_sat(255 * src_weight * src.blue + dst_weight * dst.blue, sum_alpha);
    res.alpha = div_round_sat(sum_alpha, OPAQUE_UNIT);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic olb_pkg::rgba_t px(int r, int g, int b, int a);
    olb_pkg::rgba_t p;
    p.red   = olb_pkg::pix_t'(r);
    p.green = olb_pkg::pix_t'(g);
    p.blue  = olb_pkg::pix_t'(b);
    p.alpha = olb_pkg::pix_t'(a);
    return p;
  endfunction

  // lean toward the range ends so that zero alpha and saturation come up often
  function automatic olb_pkg::pix_t rand_chan();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'd0;
    if (r == 1) return 8'd255;
    return olb_pkg::pix_t'($urandom_range(0, 255));
  endfunction

  function automatic olb_pkg::rgba_t rand_pixel();
    return px(rand_chan(), rand_chan(), rand_chan(), rand_chan());
  endfunction

  // mostly no gap or a short one, now and then a long one
  function automatic int unsigned pace_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  // call right after a rising edge; returns right after the accepting edge, or after the idle gap that follows it
  task automatic send_pixel(olb_pkg::rgba_t src, olb_pkg::rgba_t dst);
    int unsigned len;
    in_px.valid     <= 1'b1;
    in_px.src_red   <= src.red;
    in_px.src_green <= src.green;
    in_px.src_blue  <= src.blue;
    in_px.src_alpha <= src.alpha;
    in_px.dst_red   <= dst.red;
    in_px.dst_green <= dst.green;
    in_px.dst_blue  <= dst.blue;
    in_px.dst_alpha <= dst.alpha;
    @(posedge clk);
    while (!in_px.ready) @(posedge clk);
    expected_px_q.insert(expected_px_q.size(), blend_over(src, dst, opacity_model));
    if (src_gaps) begin
      len = pace_len();
      if (len != 0) begin
        in_px.valid <= 1'b0;
        repeat (len) @(posedge clk);
      end
    end
  endtask

  task automatic send_random(int count);
    repeat (count) send_pixel(rand_pixel(), rand_pixel());
  endtask

  // hold the source and wait for every outstanding pixel
  task automatic wait_drained();
    in_px.valid <= 1'b0;
    while (expected_px_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_opacity(olb_pkg::pix_t value);
    wait_drained();
    cfg_wr.valid         <= 1'b1;
    cfg_wr.layer_opacity <= value;
    @(posedge clk);
    while (!cfg_wr.ready) @(posedge clk);
    opacity_model = value;
    cfg_wr.valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_reset_opacity();
    src_gaps    = 1'b0;
    sink_pacing = 1'b0;
    // no write yet: the block must blend at full opacity
    send_pixel(px(0, 0, 0, 0), px(0, 0, 0, 0));
    send_pixel(px(0, 0, 0, 0), px(255, 128, 7, 0));
    send_pixel(px(10, 20, 30, 0), px(200, 100, 50, 0));
    send_pixel(px(255, 255, 255, 255), px(0, 0, 0, 0));
    send_pixel(px(0, 0, 0, 255), px(255, 255, 255, 255));
    send_pixel(px(255, 0, 128, 128), px(0, 255, 64, 255));
    send_pixel(px(90, 180, 45, 1), px(0, 0, 0, 0));
    send_pixel(px(255, 255, 255, 1), px(0, 0, 0, 255));
    send_pixel(px(3, 250, 77, 254), px(240, 9, 130, 1));
    send_pixel(px(255, 255, 255, 255), px(255, 255, 255, 255));
    send_pixel(px(8'hAA, 8'h55, 8'hAA, 8'h55), px(8'h55, 8'hAA, 8'h55, 8'hAA));
    send_pixel(px(1, 2, 4, 8), px(16, 32, 64, 128));
    send_pixel(px(127, 128, 129, 127), px(128, 127, 126, 128));
  endtask

  task automatic test_opacity_extremes();
    src_gaps = 1'b1;
    // zero opacity hides the source: empty destination passes, otherwise dst wins
    write_opacity(8'd0);
    send_pixel(px(255, 255, 255, 255), px(12, 34, 56, 0));
    send_pixel(px(255, 255, 255, 255), px(12, 34, 56, 200));
    send_pixel(px(0, 0, 0, 0), px(255, 255, 255, 255));
    write_opacity(8'd1);
    send_pixel(px(255, 128, 0, 255), px(0, 0, 0, 0));
    send_pixel(px(255, 128, 0, 1), px(0, 128, 255, 255));
    send_pixel(px(255, 255, 255, 255), px(0, 0, 0, 1));
    write_opacity(8'd254);
    send_pixel(px(200, 100, 50, 255), px(50, 100, 200, 255));
    send_pixel(px(255, 255, 255, 128), px(255, 255, 255, 0));
  endtask

  task automatic test_opacity_sweep();
    olb_pkg::pix_t settings[8];
    settings = '{8'd0, 8'd255, 8'd1, 8'd254, 8'd128, 8'h55, 8'hAA, 8'd0};
    settings[7] = olb_pkg::pix_t'($urandom_range(2, 253));
    foreach (settings[i]) begin
      write_opacity(settings[i]);
      // alternate the pacing so some phases run with no idling at all
      src_gaps    = (i % 2) == 0;
      sink_pacing = (i % 4) < 2;
      send_random(RANDOM_PER_PHASE);
    end
  endtask

  task automatic test_full_rate();
    write_opacity(olb_pkg::pix_t'($urandom_range(0, 255)));
    src_gaps    = 1'b0;
    sink_pacing = 1'b0;
    send_random(150);
  endtask

  task automatic test_back_pressure();
    write_opacity(8'd255);
    src_gaps    = 1'b0;
    sink_pacing = 1'b1;
    send_random(150);
  endtask

  task automatic test_drain_pause();
    src_gaps    = 1'b1;
    sink_pacing = 1'b1;
    repeat (3) begin
      send_random(30);
      wait_drained();
    end
  endtask

  initial begin
    rst_n                <= 1'b0;
    in_px.valid          <= 1'b0;
    in_px.src_red        <= '0;
    in_px.src_green      <= '0;
    in_px.src_blue       <= '0;
    in_px.src_alpha      <= '0;
    in_px.dst_red        <= '0;
    in_px.dst_green      <= '0;
    in_px.dst_blue       <= '0;
    in_px.dst_alpha      <= '0;
    cfg_wr.valid         <= 1'b0;
    cfg_wr.layer_opacity <= '0;
    opacity_model = olb_pkg::OPACITY_RESET;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_opacity();
    test_opacity_extremes();
    test_opacity_sweep();
    test_full_rate();
    test_back_pressure();
    test_drain_pause();

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Result sink pacing: ready stretches broken by stalls of random length
  initial begin : sink_pace
    int unsigned run;
    int unsigned len;
    run = 0;
    out_px.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!sink_pacing) begin
        out_px.ready <= 1'b1;
        run = 0;
      end else if (run != 0) begin
        run--;
      end else if (!out_px.ready) begin
        out_px.ready <= 1'b1;
        run = $urandom_range(0, 20);
      end else begin
        len = pace_len();
        if (len != 0) begin
          out_px.ready <= 1'b0;
          run = len - 1;
        end else begin
          run = $urandom_range(0, 20);
        end
      end
    end
  end

  // Compare every result transaction with the oldest predicted pixel
  always @(posedge clk) begin
    if (rst_n && out_px.valid && out_px.ready) begin
      got_px = px(out_px.out_red, out_px.out_green, out_px.out_blue, out_px.out_alpha);
      if (expected_px_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result r=%0d g=%0d b=%0d a=%0d",
                   got_px.red, got_px.green, got_px.blue, got_px.alpha);
      end else begin
        want_px = expected_px_q.pop_front();
        if (got_px.red != want_px.red || got_px.green != want_px.green ||
            got_px.blue != want_px.blue || got_px.alpha != want_px.alpha) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: expected r=%0d g=%0d b=%0d a=%0d, got r=%0d g=%0d b=%0d a=%0d",
                     want_px.red, want_px.green, want_px.blue, want_px.alpha,
                     got_px.red, got_px.green, got_px.blue, got_px.alpha);
        end
      end
    end
  end

  // Watchdog: too long without any transaction on any channel
  always @(posedge clk) begin
    if ((in_px.valid && in_px.ready) || (out_px.valid && out_px.ready) ||
        (cfg_wr.valid && cfg_wr.ready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", STUCK_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

endmodule

/* layer_opacity_over_blend_top.f */
design/olb_pkg.sv
design/olb_if.sv
design/olb_div.sv
design/layer_opacity_over_blend_top.sv
design/olb_checker.sv
sim/tb_layer_opacity_over_blend_top.sv
